FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: src/prx_pkg.sv
// ---------------------------------------------------------------------------
// prx_pkg
// Widths, types and helpers for the 3D point rotation pipeline.
// ---------------------------------------------------------------------------
package prx_pkg;

  localparam int COORD_W   = 32;
  localparam int TRIG_W    = 16;
  localparam int TRIG_FRAC = 14;
  localparam int PROD_W    = COORD_W + TRIG_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int NUM_REGS  = 6;
  localparam int CFG_IDX_W = 3;
  localparam int DATA_BITS = 3 * COORD_W;
  localparam int TDATA_W   = ((DATA_BITS + 7) / 8) * 8;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [TRIG_W-1:0]  trig_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  localparam trig_t TRIG_ZERO = trig_t'(0);
  localparam trig_t TRIG_ONE  = trig_t'(1 << TRIG_FRAC);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIN_X = 3'd0,
    REG_COS_X = 3'd1,
    REG_SIN_Y = 3'd2,
    REG_COS_Y = 3'd3,
    REG_SIN_Z = 3'd4,
    REG_COS_Z = 3'd5
  } reg_idx_e;

  // pair being rotated, the untouched axis and the frame marker
  typedef struct packed {
    coord_t first;
    coord_t second;
    coord_t keep;
    logic   last;
  } rot_pkt_t;

  typedef struct packed {
    trig_t sin_v;
    trig_t cos_v;
  } trig_pair_t;

  typedef struct packed {
    logic mul_valid;
    logic sum_valid;
  } stage_stat_t;

  function automatic coord_t sat_coord(input sum_t v);
    logic [SUM_W-COORD_W:0] top;
    top = v[SUM_W-1:COORD_W-1];
    if ((&top) || !(|top)) begin
      return v[COORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

FILE: src/point_rotate_xyz.sv
// ---------------------------------------------------------------------------
// point_rotate_xyz
// Streams 3D Q16.16 points through rotations about X, then Y, then Z.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis_*: one point per request, tdata = {z, y, x} with x in
//   the low 32 bits, tlast marks the final point of an object.
//   Master stream m_axis_*: the rotated point in the same packing, tlast a
//   copy of the input marker. One result per request, in order.
//   Config port: cfg_we_i writes cfg_wdata_i (Q1.14 sine/cosine) into the
//   register cfg_idx_i (0 sin X, 1 cos X, 2 sin Y, 3 cos Y, 4 sin Z, 5 cos Z);
//   other indexes are ignored. Write only while the pipe is empty.
//   Each axis is a multiply stage, then an add/shift/saturate stage.
//   Throughput: one point per cycle while m_axis_tready does not stall it.
//   Reset clears all stage valids and loads the identity rotation.
//   When m_axis_tready is low, empty stages keep filling; s_axis_tready drops
//   only once all six stages hold a point.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module point_rotate_xyz (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // coord_x, coord_y, coord_z
  input  logic [prx_pkg::TDATA_W-1:0]            s_axis_tdata,
  input  logic                                   s_axis_tlast,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // rotated_x, rotated_y, rotated_z
  output logic [prx_pkg::TDATA_W-1:0]            m_axis_tdata,
  output logic                                   m_axis_tlast,
  input  logic                                   cfg_we_i,
  input  logic [prx_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [prx_pkg::TRIG_W-1:0]             cfg_wdata_i
);

  localparam int CW = prx_pkg::COORD_W;

  prx_pkg::trig_t [prx_pkg::NUM_REGS-1:0] cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (prx_pkg::reg_idx_e'(cfg_idx_i))
        prx_pkg::REG_SIN_X: cfg_d[prx_pkg::REG_SIN_X] = cfg_wdata_i;
        prx_pkg::REG_COS_X: cfg_d[prx_pkg::REG_COS_X] = cfg_wdata_i;
        prx_pkg::REG_SIN_Y: cfg_d[prx_pkg::REG_SIN_Y] = cfg_wdata_i;
        prx_pkg::REG_COS_Y: cfg_d[prx_pkg::REG_COS_Y] = cfg_wdata_i;
        prx_pkg::REG_SIN_Z: cfg_d[prx_pkg::REG_SIN_Z] = cfg_wdata_i;
        prx_pkg::REG_COS_Z: cfg_d[prx_pkg::REG_COS_Z] = cfg_wdata_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[prx_pkg::REG_SIN_X] <= prx_pkg::TRIG_ZERO;
      cfg_q[prx_pkg::REG_COS_X] <= prx_pkg::TRIG_ONE;
      cfg_q[prx_pkg::REG_SIN_Y] <= prx_pkg::TRIG_ZERO;
      cfg_q[prx_pkg::REG_COS_Y] <= prx_pkg::TRIG_ONE;
      cfg_q[prx_pkg::REG_SIN_Z] <= prx_pkg::TRIG_ZERO;
      cfg_q[prx_pkg::REG_COS_Z] <= prx_pkg::TRIG_ONE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  prx_pkg::trig_pair_t trig_x, trig_y, trig_z;
  assign trig_x = '{sin_v: cfg_q[prx_pkg::REG_SIN_X], cos_v: cfg_q[prx_pkg::REG_COS_X]};
  assign trig_y = '{sin_v: cfg_q[prx_pkg::REG_SIN_Y], cos_v: cfg_q[prx_pkg::REG_COS_Y]};
  assign trig_z = '{sin_v: cfg_q[prx_pkg::REG_SIN_Z], cos_v: cfg_q[prx_pkg::REG_COS_Z]};

  prx_pkg::rot_pkt_t pkt_x_in, pkt_x_out, pkt_y_in, pkt_y_out, pkt_z_in, pkt_z_out;
  logic vx, rx, vy, ry;
  prx_pkg::stage_stat_t stat_x, stat_y, stat_z;

  // about X: (y, z), keep x
  assign pkt_x_in.first  = s_axis_tdata[2*CW-1:CW];
  assign pkt_x_in.second = s_axis_tdata[3*CW-1:2*CW];
  assign pkt_x_in.keep   = s_axis_tdata[CW-1:0];
  assign pkt_x_in.last   = s_axis_tlast;

  prx_rot_stage u_rot_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .trig_i     (trig_x),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_pkt_i   (pkt_x_in),
    .out_valid_o(vx),
    .out_ready_i(rx),
    .out_pkt_o  (pkt_x_out),
    .stat_o     (stat_x)
  );

  // about Y: (x, z), keep y
  assign pkt_y_in.first  = pkt_x_out.keep;
  assign pkt_y_in.second = pkt_x_out.second;
  assign pkt_y_in.keep   = pkt_x_out.first;
  assign pkt_y_in.last   = pkt_x_out.last;

  prx_rot_stage u_rot_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .trig_i     (trig_y),
    .in_valid_i (vx),
    .in_ready_o (rx),
    .in_pkt_i   (pkt_y_in),
    .out_valid_o(vy),
    .out_ready_i(ry),
    .out_pkt_o  (pkt_y_out),
    .stat_o     (stat_y)
  );

  // about Z: (x, y), keep z
  assign pkt_z_in.first  = pkt_y_out.first;
  assign pkt_z_in.second = pkt_y_out.keep;
  assign pkt_z_in.keep   = pkt_y_out.second;
  assign pkt_z_in.last   = pkt_y_out.last;

  prx_rot_stage u_rot_z (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .trig_i     (trig_z),
    .in_valid_i (vy),
    .in_ready_o (ry),
    .in_pkt_i   (pkt_z_in),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_pkt_o  (pkt_z_out),
    .stat_o     (stat_z)
  );

  assign m_axis_tdata = prx_pkg::TDATA_W'({pkt_z_out.keep, pkt_z_out.second,
                                           pkt_z_out.first});
  assign m_axis_tlast = pkt_z_out.last;

  `ASSERT_IMPLY(a_full_when_blocked, !s_axis_tready, (&{stat_x, stat_y, stat_z}))
  `ASSERT_IMPLY(a_ready_flows_back, m_axis_tready, s_axis_tready)
  `ASSERT_NEXT(a_bad_idx_ignored, (cfg_we_i && (cfg_idx_i > prx_pkg::REG_COS_Z)), $stable(cfg_q))

endmodule

FILE: src/prx_rot_stage.sv
// ---------------------------------------------------------------------------
// prx_rot_stage
// One single-axis rotation: a multiply stage and an add/shift/saturate stage.
// ---------------------------------------------------------------------------
module prx_rot_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  prx_pkg::trig_pair_t   trig_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  prx_pkg::rot_pkt_t     in_pkt_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output prx_pkg::rot_pkt_t     out_pkt_o,
  output prx_pkg::stage_stat_t  stat_o
);

  logic mul_v_q, sum_v_q;
  logic mul_rdy, sum_rdy;

  prx_pkg::prod_t fc_q, gs_q, fs_q, gc_q;
  prx_pkg::prod_t fc_d, gs_d, fs_d, gc_d;
  prx_pkg::coord_t keep1_q;
  logic last1_q;

  prx_pkg::sum_t nf_sum, ng_sum, nf_shr, ng_shr;
  prx_pkg::rot_pkt_t out_q, out_d;

  assign sum_rdy    = !sum_v_q || out_ready_i;
  assign mul_rdy    = !mul_v_q || sum_rdy;
  assign in_ready_o = mul_rdy;

  always_comb begin
    fc_d = prx_pkg::PROD_W'(in_pkt_i.first)  * prx_pkg::PROD_W'(trig_i.cos_v);
    gs_d = prx_pkg::PROD_W'(in_pkt_i.second) * prx_pkg::PROD_W'(trig_i.sin_v);
    fs_d = prx_pkg::PROD_W'(in_pkt_i.first)  * prx_pkg::PROD_W'(trig_i.sin_v);
    gc_d = prx_pkg::PROD_W'(in_pkt_i.second) * prx_pkg::PROD_W'(trig_i.cos_v);
  end

  // exact sums, floor shift
  always_comb begin
    nf_sum = prx_pkg::SUM_W'(fc_q) + prx_pkg::SUM_W'(gs_q);
    ng_sum = prx_pkg::SUM_W'(gc_q) - prx_pkg::SUM_W'(fs_q);
    nf_shr = nf_sum >>> prx_pkg::TRIG_FRAC;
    ng_shr = ng_sum >>> prx_pkg::TRIG_FRAC;
    out_d.first  = prx_pkg::sat_coord(nf_shr);
    out_d.second = prx_pkg::sat_coord(ng_shr);
    out_d.keep   = keep1_q;
    out_d.last   = last1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
      sum_v_q <= 1'b0;
    end else begin
      if (mul_rdy) mul_v_q <= in_valid_i;
      if (sum_rdy) sum_v_q <= mul_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && mul_rdy) begin
      fc_q    <= fc_d;
      gs_q    <= gs_d;
      fs_q    <= fs_d;
      gc_q    <= gc_d;
      keep1_q <= in_pkt_i.keep;
      last1_q <= in_pkt_i.last;
    end
    if (mul_v_q && sum_rdy) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o      = sum_v_q;
  assign out_pkt_o        = out_q;
  assign stat_o.mul_valid = mul_v_q;
  assign stat_o.sum_valid = sum_v_q;

endmodule
